/* hdl/lbpe_pkg.sv */
// ----------------------------------------------------------------------------
// lbpe_pkg
// Shared constants and tables for the LED bit pulse encoder.
// ----------------------------------------------------------------------------
package lbpe_pkg;

    // PWM compare codes for one and zero bits
    localparam logic [5:0] CODE_ZERO = 6'd27;
    localparam logic [5:0] CODE_ONE  = 6'd53;

    localparam int BITS_PER_LED = 24;
    localparam int COUNT_W      = 5;
    localparam int LANES        = 3;
    localparam int TEMP_ENTRIES = 5;
    localparam int LANE_STAGES  = 5;

    // Divisor 255*255*255 and its double, sized for the remainder path
    localparam logic [23:0] SCALE_DIVISOR = 24'd16581375;
    localparam logic [25:0] SCALE_DIV_R1  = 26'd16581375;
    localparam logic [25:0] SCALE_DIV_R2  = 26'd33162750;

    // 2^18 / (divisor / 2^16), rounded down so the estimate never overshoots
    localparam logic [10:0] SCALE_RECIP = 11'd1036;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;

    // Register index of brightness
    localparam logic REG_BRIGHTNESS = 1'b0;

    localparam logic [2:0] TEMP_LAST = 3'd4;

    // Temperature byte times per-channel correction byte (176, 255, 240)
    localparam logic [15:0] TEMP_CORR_TABLE [0:TEMP_ENTRIES-1][0:LANES-1] = '{
        '{16'd44880, 16'd65025, 16'd61200},
        '{16'd25872, 16'd65025, 16'd9840},
        '{16'd42416, 16'd65025, 16'd53760},
        '{16'd41360, 16'd54060, 16'd61200},
        '{16'd42944, 16'd65025, 16'd58080}
    };

endpackage

/* hdl/lbpe_lane.sv */
// ----------------------------------------------------------------------------
// lbpe_lane
// One color channel: scale a byte by brightness and the temperature and
// correction factor, then divide by 255^3 with a reciprocal estimate and a
// remainder correction. Five register stages, all held while en is low.
// ----------------------------------------------------------------------------
module lbpe_lane (
    input  logic        clk,
    input  logic        en,
    input  logic [7:0]  color,
    input  logic [7:0]  brightness,
    input  logic [15:0] factor,
    output logic [7:0]  scaled
);
    import lbpe_pkg::*;

    logic [15:0] cb_reg;
    logic [15:0] tc_reg;
    logic [31:0] prod_reg;
    logic [31:0] prod_c_reg;
    logic [7:0]  q0_reg;
    logic [7:0]  q0_d_reg;
    logic [25:0] rem_reg;
    logic [7:0]  q_reg;

    logic [15:0] cb_next;
    logic [31:0] prod_next;
    logic [26:0] est;
    logic [31:0] q0_mul;
    logic [31:0] rem_full;
    logic [7:0]  q_next;

    // Color times brightness
    assign cb_next = {8'b0, color} * {8'b0, brightness};

    // Full product, at most 255^4
    assign prod_next = {16'b0, cb_reg} * {16'b0, tc_reg};

    // Quotient estimate from the upper half, low by at most two
    assign est = {11'b0, prod_reg[31:16]} * {16'b0, SCALE_RECIP};

    // Remainder left by the estimate
    assign q0_mul   = {24'b0, q0_reg} * {8'b0, SCALE_DIVISOR};
    assign rem_full = prod_c_reg - q0_mul;

    // Correct the estimate
    always_comb
    begin
        if (rem_reg >= SCALE_DIV_R2)
        begin
            q_next = q0_d_reg + 8'd2;
        end
        else if (rem_reg >= SCALE_DIV_R1)
        begin
            q_next = q0_d_reg + 8'd1;
        end
        else
        begin
            q_next = q0_d_reg;
        end
    end

    // Advance the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cb_reg     <= cb_next;
            tc_reg     <= factor;
            prod_reg   <= prod_next;
            prod_c_reg <= prod_reg;
            q0_reg     <= est[25:18];
            q0_d_reg   <= q0_reg;
            rem_reg    <= rem_full[25:0];
            q_reg      <= q_next;
        end
    end

    assign scaled = q_reg;

endmodule

/* hdl/lbpe_serializer.sv */
// ----------------------------------------------------------------------------
// lbpe_serializer
// Shift a 24-bit scaled color out as one pulse code per word, most
// significant bit first, and mark the last code of the LED.
// ----------------------------------------------------------------------------
module lbpe_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    input  logic [23:0] load_color,
    output logic        load_take,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pulse_code,
    output logic        last_of_led
);
    import lbpe_pkg::*;

    logic [23:0]        shift_reg;
    logic [23:0]        shift_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               busy_reg;
    logic               busy_next;
    logic               is_last;
    logic               out_fire;

    assign is_last   = (count_reg == COUNT_W'(BITS_PER_LED - 1));
    assign out_fire  = busy_reg && out_ready;
    assign load_take = load_valid && (!busy_reg || (out_fire && is_last));

    // Load a new color, shift on each accepted word, drop when done
    always_comb
    begin
        shift_next = shift_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        if (load_take)
        begin
            shift_next = load_color;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (out_fire)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                shift_next = {shift_reg[22:0], 1'b0};
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign out_valid   = busy_reg;
    assign pulse_code  = shift_reg[23] ? CODE_ONE : CODE_ZERO;
    assign last_of_led = is_last;

endmodule

/* hdl/led_bit_pulse_encoder.sv */
// ----------------------------------------------------------------------------
// led_bit_pulse_encoder
// Path: the first pulse code of an LED becomes valid after its word is
// accepted and passes the 5 lane stages, merge register and serializer load.
// Throughput: one pulse code per cycle while out_ready is high, set by the
// serializer; the next LED waits in the merge register and follows at once.
// Reset: rst_n clears all valid and count state and sets brightness to 255.
// ----------------------------------------------------------------------------
module led_bit_pulse_encoder (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  first_byte,
    input  logic [7:0]  second_byte,
    input  logic [7:0]  third_byte,
    input  logic [2:0]  temperature_select,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  pulse_code,
    output logic        last_of_led
);
    import lbpe_pkg::*;

    logic [7:0]             brightness_reg;
    logic [LANE_STAGES-1:0] stage_valid_reg;
    logic [23:0]            merge_color_reg;
    logic                   merge_valid_reg;
    logic                   merge_valid_next;
    logic                   en;
    logic [2:0]             sel;
    logic [7:0]             lane_color  [LANES];
    logic [7:0]             lane_scaled [LANES];
    logic                   load_take;
    logic                   cfg_write;
    logic                   lane_done;

    // Configuration writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_BRIGHTNESS))
        begin
            brightness_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_BRIGHTNESS) ? {24'b0, brightness_reg} : 32'b0;

    // Hold the lanes only when a finished word cannot move into the merge register
    assign lane_done = stage_valid_reg[LANE_STAGES-1];
    assign en        = !(lane_done && merge_valid_reg);
    assign in_ready  = en;

    // Saturate the temperature select to the last table entry
    assign sel = (temperature_select > TEMP_LAST) ? TEMP_LAST : temperature_select;

    assign lane_color[0] = first_byte;
    assign lane_color[1] = second_byte;
    assign lane_color[2] = third_byte;

    // One lane per color channel
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        lbpe_lane u_lane (
            .clk        (clk),
            .en         (en),
            .color      (lane_color[k]),
            .brightness (brightness_reg),
            .factor     (TEMP_CORR_TABLE[sel][k]),
            .scaled     (lane_scaled[k])
        );
    end

    // Track which lane stages hold a word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else if (en)
        begin
            stage_valid_reg <= {stage_valid_reg[LANE_STAGES-2:0], in_valid};
        end
    end

    // Merge the three lanes into one color word
    always_comb
    begin
        merge_valid_next = merge_valid_reg;
        if (load_take)
        begin
            merge_valid_next = 1'b0;
        end
        else if (lane_done && !merge_valid_reg)
        begin
            merge_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_valid_reg <= 1'b0;
        end
        else
        begin
            merge_valid_reg <= merge_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_done && !merge_valid_reg)
        begin
            merge_color_reg <= {lane_scaled[0], lane_scaled[1], lane_scaled[2]};
        end
    end

    lbpe_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (merge_valid_reg),
        .load_color  (merge_color_reg),
        .load_take   (load_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pulse_code  (pulse_code),
        .last_of_led (last_of_led)
    );

endmodule
